FILE: design/csirfg_pkg.sv
`default_nettype none

package csirfg_pkg;

    localparam int HDR_BYTES = 20;

    // Header byte positions used by the emitter; position 20 is the first payload byte
    localparam logic [4:0] HDR_LAST = 5'd19;
    localparam logic [4:0] PAY_IDX  = 5'd20;

    localparam logic [1:0] CFG_NODE_ID      = 2'd0;
    localparam logic [1:0] CFG_MIN_INTERVAL = 2'd1;
    localparam logic [1:0] CFG_MAGIC_WORD   = 2'd2;

    localparam logic [7:0]  NODE_ID_RST      = 8'd1;
    localparam logic [19:0] MIN_INTERVAL_RST = 20'd20000;
    localparam logic [31:0] MAGIC_WORD_RST   = 32'd0;

    localparam logic [7:0] HDR_VERSION = 8'd1;

    typedef struct packed {
        logic              first_byte;
        logic [7:0]        iq_byte;
        logic [9:0]        iq_length;
        logic [7:0]        channel;
        logic signed [7:0] rssi;
        logic signed [7:0] noise_level;
        logic [62:0]       now_us;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       run_end;
    } result_t;

    // Centre frequency in MHz; 5885 at most, so 13 bits
    function automatic logic [12:0] freq_of_channel(input logic [7:0] ch);
        logic [15:0] ch16;
        logic [15:0] f;
        ch16 = {8'd0, ch};
        if (ch >= 8'd1 && ch <= 8'd13)
            f = 16'd2407 + ch16 * 16'd5;
        else if (ch == 8'd14)
            f = 16'd2484;
        else if (ch >= 8'd36 && ch <= 8'd177)
            f = 16'd5000 + ch16 * 16'd5;
        else
            f = 16'd0;
        return f[12:0];
    endfunction

endpackage

`default_nettype wire

FILE: design/csi_record_framer_rate_gate_top.sv
`default_nettype none

// Channel   Handshake              Payload
// input     in_valid / in_stall    first_byte iq_byte iq_length channel rssi noise_level now_us
// output    out_valid / out_stall  out_byte frame_end run_end
// config    cfg_write              cfg_index cfg_data
//
// Payload bytes pass one per cycle while out_stall is low, via the input and result registers.
// A record start that passes the gate and fits in MAX_FRAME_BYTES emits 20 header bytes, plus
// its first payload byte when iq_length is not zero, one per cycle from the header emitter
// while out_stall is low; the input stalls while they go out.
// Dropped items are consumed and give no transfer.
// Reset clears the gate time, sequence and frame state and loads the register defaults.
// out_stall holds the result register and backs up to in_stall in the same cycle.

module csi_record_framer_rate_gate_top
    import csirfg_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 512
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [31:0]       cfg_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              first_byte,
    input  wire logic [7:0]        iq_byte,
    input  wire logic [9:0]        iq_length,
    input  wire logic [7:0]        channel,
    input  wire logic signed [7:0] rssi,
    input  wire logic signed [7:0] noise_level,
    input  wire logic [62:0]       now_us,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [7:0]             out_byte,
    output logic                   frame_end,
    output logic                   run_end
);

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    consume;
    logic    res_ready;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign in_item.first_byte  = first_byte;
    assign in_item.iq_byte     = iq_byte;
    assign in_item.iq_length   = iq_length;
    assign in_item.channel     = channel;
    assign in_item.rssi        = rssi;
    assign in_item.noise_level = noise_level;
    assign in_item.now_us      = now_us;

    csirfg_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .consume    (consume)
    );

    csirfg_framer #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_framer (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .consume    (consume),
        .res_ready  (res_ready),
        .res_valid  (res_valid),
        .res        (res)
    );

    csirfg_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign out_byte  = out_res.out_byte;
    assign frame_end = out_res.frame_end;
    assign run_end   = out_res.run_end;

endmodule

`default_nettype wire

FILE: design/csirfg_in_reg.sv
`default_nettype none

module csirfg_in_reg
    import csirfg_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire item_t in_item,
    output logic       item_valid,
    output item_t      item,
    input  wire logic  consume
);

    logic  item_valid_reg;
    logic  item_valid_next;
    item_t item_reg;
    logic  accept;

    assign in_stall = item_valid_reg && !consume;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (accept)
            item_valid_next = 1'b1;
        else if (consume)
            item_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else
            item_valid_reg <= item_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= in_item;
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

FILE: design/csirfg_framer.sv
`default_nettype none

module csirfg_framer
    import csirfg_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 512
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        item_valid,
    input  wire item_t       item,
    output logic             consume,
    input  wire logic        res_ready,
    output logic             res_valid,
    output result_t          res
);

    logic [7:0]  node_id_reg;
    logic [19:0] min_interval_reg;
    logic [31:0] magic_reg;

    logic [31:0] seq_reg,       seq_next;
    logic [62:0] last_time_reg, last_time_next;
    logic [9:0]  rem_reg,       rem_next;
    logic        hdr_active_reg, hdr_active_next;
    logic [4:0]  hdr_idx_reg,   hdr_idx_next;

    // Header fields captured when a record passes the gate and fits in a frame
    logic              hdr_load;
    logic [12:0]       freq_reg;
    logic [8:0]        sub_reg;
    logic signed [7:0] rssi_reg;
    logic signed [7:0] nf_reg;
    logic [7:0]        pay_byte_reg;
    logic              len_zero_reg;
    logic              len_one_reg;

    logic [63:0] gap;
    logic        too_early;
    logic        fits;
    logic [7:0]  hdr_byte;
    logic        hdr_last;

    assign gap       = {1'b0, item.now_us} - {1'b0, last_time_reg};
    assign too_early = gap[63] || (gap[62:0] < {43'd0, min_interval_reg});
    assign fits      = ({1'b0, item.iq_length} + 11'(HDR_BYTES)) <= 11'(MAX_FRAME_BYTES);
    assign hdr_last  = len_zero_reg ? (hdr_idx_reg == HDR_LAST) : (hdr_idx_reg == PAY_IDX);

    always_comb
    begin
        case (hdr_idx_reg)
            5'd0:    hdr_byte = magic_reg[7:0];
            5'd1:    hdr_byte = magic_reg[15:8];
            5'd2:    hdr_byte = magic_reg[23:16];
            5'd3:    hdr_byte = magic_reg[31:24];
            5'd4:    hdr_byte = node_id_reg;
            5'd5:    hdr_byte = HDR_VERSION;
            5'd6:    hdr_byte = sub_reg[7:0];
            5'd7:    hdr_byte = {7'd0, sub_reg[8]};
            5'd8:    hdr_byte = freq_reg[7:0];
            5'd9:    hdr_byte = {3'd0, freq_reg[12:8]};
            5'd12:   hdr_byte = seq_reg[7:0];
            5'd13:   hdr_byte = seq_reg[15:8];
            5'd14:   hdr_byte = seq_reg[23:16];
            5'd15:   hdr_byte = seq_reg[31:24];
            5'd16:   hdr_byte = rssi_reg;
            5'd17:   hdr_byte = nf_reg;
            5'd20:   hdr_byte = pay_byte_reg;
            default: hdr_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        seq_next        = seq_reg;
        last_time_next  = last_time_reg;
        rem_next        = rem_reg;
        hdr_active_next = hdr_active_reg;
        hdr_idx_next    = hdr_idx_reg;
        hdr_load        = 1'b0;
        consume         = 1'b0;
        res_valid       = 1'b0;
        res             = '0;

        if (hdr_active_reg) begin
            if (res_ready) begin
                res_valid     = 1'b1;
                res.out_byte  = hdr_byte;
                res.frame_end = hdr_last && (len_zero_reg || len_one_reg);
                res.run_end   = hdr_last;
                hdr_idx_next  = hdr_idx_reg + 5'd1;
                if (hdr_last) begin
                    hdr_active_next = 1'b0;
                    seq_next        = seq_reg + 32'd1;
                end
            end
        end else if (item_valid && res_ready) begin
            consume = 1'b1;
            if (item.first_byte) begin
                rem_next = 10'd0;
                if (!too_early) begin
                    last_time_next = item.now_us;
                    if (fits) begin
                        hdr_load        = 1'b1;
                        rem_next        = (item.iq_length == 10'd0) ? 10'd0
                                                                    : item.iq_length - 10'd1;
                        // byte 0 goes out in the same cycle
                        res_valid       = 1'b1;
                        res.out_byte    = magic_reg[7:0];
                        hdr_active_next = 1'b1;
                        hdr_idx_next    = 5'd1;
                    end
                end
            end else if (rem_reg != 10'd0) begin
                rem_next      = rem_reg - 10'd1;
                res_valid     = 1'b1;
                res.out_byte  = item.iq_byte;
                res.frame_end = (rem_reg == 10'd1);
                res.run_end   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            node_id_reg      <= NODE_ID_RST;
            min_interval_reg <= MIN_INTERVAL_RST;
            magic_reg        <= MAGIC_WORD_RST;
        end else if (cfg_write) begin
            unique case (cfg_index)
                CFG_NODE_ID:      node_id_reg      <= cfg_data[7:0];
                CFG_MIN_INTERVAL: min_interval_reg <= cfg_data[19:0];
                CFG_MAGIC_WORD:   magic_reg        <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            seq_reg        <= 32'd0;
            last_time_reg  <= 63'd0;
            rem_reg        <= 10'd0;
            hdr_active_reg <= 1'b0;
            hdr_idx_reg    <= 5'd0;
        end else begin
            seq_reg        <= seq_next;
            last_time_reg  <= last_time_next;
            rem_reg        <= rem_next;
            hdr_active_reg <= hdr_active_next;
            hdr_idx_reg    <= hdr_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hdr_load) begin
            freq_reg     <= freq_of_channel(item.channel);
            sub_reg      <= item.iq_length[9:1];
            rssi_reg     <= item.rssi;
            nf_reg       <= item.noise_level;
            pay_byte_reg <= item.iq_byte;
            len_zero_reg <= (item.iq_length == 10'd0);
            len_one_reg  <= (item.iq_length == 10'd1);
        end
    end

endmodule

`default_nettype wire

FILE: design/csirfg_out_reg.sv
`default_nettype none

module csirfg_out_reg
    import csirfg_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    res_valid,
    input  wire result_t res,
    output logic         res_ready,
    output logic         out_valid,
    input  wire logic    out_stall,
    output result_t      out_res
);

    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;

    // free when empty or when the held result transfers this cycle
    assign res_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ready)
            out_valid_next = res_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
            out_res_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

`default_nettype wire
